// ===== sv/sorted_coo_to_csr_writer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted COO to CSR writer
// Implication and next-cycle checks, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTED_COO_TO_CSR_WRITER_CORE_ASSERT_SVH
`define SORTED_COO_TO_CSR_WRITER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define SCTW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SCTW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SCTW_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCTW_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/sctw_pkg.sv =====
// ----------------------------------------------------------------------------
// sctw_pkg
// Codes, register indexes and shared types of the COO to CSR writer.
// ----------------------------------------------------------------------------
`default_nettype none

package sctw_pkg;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_ENTRY = 2'd1;
   localparam logic [1:0] OP_END   = 2'd2;

   localparam logic [1:0] KIND_RUN   = 2'd0;
   localparam logic [1:0] KIND_EDGE  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;
   localparam logic [1:0] KIND_DONE  = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_ORDER    = 2'd1;
   localparam logic [1:0] ERR_RANGE    = 2'd2;
   localparam logic [1:0] ERR_MISMATCH = 2'd3;

   localparam logic [2:0] CSR_ROW_COUNT   = 3'd0;
   localparam logic [2:0] CSR_COLUMN_COUNT = 3'd1;
   localparam logic [2:0] CSR_EXPECTED_NNZ = 3'd2;
   localparam logic [2:0] CSR_TRANSPOSE    = 3'd3;
   localparam logic [2:0] CSR_ENTRY_LIMIT  = 3'd4;

   typedef struct packed {
      logic [31:0] row_count;
      logic [31:0] column_count;
      logic [31:0] expected_nonzeros;
      logic        transpose_mode;
      logic [31:0] entry_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] offset_value;
      logic [33:0] run_length;
      logic [31:0] edge_target;
      logic [63:0] weight_out;
      logic [1:0]  error_code;
      logic        last_of_run;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/sorted_coo_to_csr_writer_core.sv =====
// ----------------------------------------------------------------------------
// sorted_coo_to_csr_writer_core
// The input register holds an item from acceptance; each of its results is
// loaded from the step logic into the result register when that is free.
// Two results of one item go one after the other through the single result
// register port, which sets the rate; a new item is taken as the held one ends.
// Reset: synchronous; clears stream state, registers to reset values, no item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_coo_to_csr_writer_core_assert.svh"

module sorted_coo_to_csr_writer_core
   import sctw_pkg::*;
#(
   parameter int INDEX_BITS = 32
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_row_number,
   input  wire logic [31:0] req_column_number,
   input  wire logic [63:0] req_entry_weight,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_result_kind,
   output logic [31:0]      rsp_offset_value,
   output logic [33:0]      rsp_run_length,
   output logic [31:0]      rsp_edge_target,
   output logic [63:0]      rsp_weight_out,
   output logic [1:0]       rsp_error_code,
   output logic             rsp_last_of_run
);

   cfg_type cfg;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [1:0]  opcode_ff;
   logic [31:0] row_ff;
   logic [31:0] column_ff;
   logic [63:0] weight_ff;
   logic        beat_ff;
   logic        beat_in;

   logic [31:0]           prev_index_ff;
   logic [INDEX_BITS-1:0] edges_seen_ff;
   logic [31:0]           line_counter_ff;
   logic                  limit_reached_ff;
   logic [31:0]           prev_index_in;
   logic [INDEX_BITS-1:0] edges_seen_in;
   logic [31:0]           line_counter_in;
   logic                  limit_reached_in;

   logic [1:0]  result_count;
   result_type  step_result;
   result_type  rsp_result;
   logic        is_last;
   logic        out_free;
   logic        step_fire;
   logic        item_done;
   logic        req_take;
   logic        rsp_final;

   sctw_cfg u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sctw_step #(
      .INDEX_BITS (INDEX_BITS)
   ) u_step (
      .opcode           (opcode_ff),
      .row_number       (row_ff),
      .column_number    (column_ff),
      .entry_weight     (weight_ff),
      .cfg              (cfg),
      .beat             (beat_ff),
      .prev_index       (prev_index_ff),
      .edges_seen       (edges_seen_ff),
      .line_counter     (line_counter_ff),
      .limit_reached    (limit_reached_ff),
      .result_count     (result_count),
      .result           (step_result),
      .is_last          (is_last),
      .prev_index_in    (prev_index_in),
      .edges_seen_in    (edges_seen_in),
      .line_counter_in  (line_counter_in),
      .limit_reached_in (limit_reached_in)
   );

   assign step_fire = in_valid_ff && ((result_count == 2'd0) || out_free);
   assign item_done = step_fire && ((result_count == 2'd0) || is_last);
   assign req_ready = !reset && (!in_valid_ff || item_done);
   assign req_take  = req_valid && req_ready;

   sctw_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step_fire && (result_count != 2'd0)),
      .result     (step_result),
      .rsp_ready  (rsp_ready),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_result (rsp_result)
   );

   always_comb begin
      in_valid_in = req_take || (in_valid_ff && !item_done);
      beat_in     = beat_ff;
      if (item_done) begin
         beat_in = 1'b0;
      end else if (step_fire) begin
         beat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         beat_ff          <= 1'b0;
         prev_index_ff    <= 32'd0;
         edges_seen_ff    <= '0;
         line_counter_ff  <= 32'd1;
         limit_reached_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         beat_ff     <= beat_in;
         if (item_done) begin
            prev_index_ff    <= prev_index_in;
            edges_seen_ff    <= edges_seen_in;
            line_counter_ff  <= line_counter_in;
            limit_reached_ff <= limit_reached_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         opcode_ff <= req_opcode;
         row_ff    <= req_row_number;
         column_ff <= req_column_number;
         weight_ff <= req_entry_weight;
      end
   end

   assign rsp_result_kind  = rsp_result.result_kind;
   assign rsp_offset_value = rsp_result.offset_value;
   assign rsp_run_length   = rsp_result.run_length;
   assign rsp_edge_target  = rsp_result.edge_target;
   assign rsp_weight_out   = rsp_result.weight_out;
   assign rsp_error_code   = rsp_result.error_code;
   assign rsp_last_of_run  = rsp_result.last_of_run;

   assign rsp_final = rsp_valid &&
                      (rsp_result_kind == KIND_DONE || rsp_result_kind == KIND_ERROR);

   `SCTW_ASSERT_IMP(a_beat_needs_item, clock, reset, beat_ff, in_valid_ff)
   `SCTW_ASSERT_NXT(a_take_starts_beat0, clock, reset, req_take, in_valid_ff && !beat_ff)
   `SCTW_ASSERT_IMP(a_final_kinds_last, clock, reset, rsp_final, rsp_last_of_run)

endmodule

`default_nettype wire

// ===== sv/sctw_cfg.sv =====
// ----------------------------------------------------------------------------
// sctw_cfg
// Configuration registers written through the CSR port.
// ----------------------------------------------------------------------------
`default_nettype none

module sctw_cfg
   import sctw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_COUNT:    cfg_in.row_count         = csr_write_data;
            CSR_COLUMN_COUNT: cfg_in.column_count      = csr_write_data;
            CSR_EXPECTED_NNZ: cfg_in.expected_nonzeros = csr_write_data;
            CSR_TRANSPOSE:    cfg_in.transpose_mode    = csr_write_data[0];
            CSR_ENTRY_LIMIT:  cfg_in.entry_limit       = csr_write_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count         <= 32'd1;
         cfg_ff.column_count      <= 32'd1;
         cfg_ff.expected_nonzeros <= 32'd0;
         cfg_ff.transpose_mode    <= 1'b0;
         cfg_ff.entry_limit       <= 32'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== sv/sctw_step.sv =====
// ----------------------------------------------------------------------------
// sctw_step
// Result of one beat of a held item, result count and next stream state.
// ----------------------------------------------------------------------------
`default_nettype none

module sctw_step
   import sctw_pkg::*;
#(
   parameter int INDEX_BITS = 32
)
(
   input  wire logic [1:0]            opcode,
   input  wire logic [31:0]           row_number,
   input  wire logic [31:0]           column_number,
   input  wire logic [63:0]           entry_weight,
   input  wire cfg_type               cfg,
   input  wire logic                  beat,
   input  wire logic [31:0]           prev_index,
   input  wire logic [INDEX_BITS-1:0] edges_seen,
   input  wire logic [31:0]           line_counter,
   input  wire logic                  limit_reached,
   output logic [1:0]                 result_count,
   output result_type                 result,
   output logic                       is_last,
   output logic [31:0]                prev_index_in,
   output logic [INDEX_BITS-1:0]      edges_seen_in,
   output logic [31:0]                line_counter_in,
   output logic                       limit_reached_in
);

   localparam logic [31:0] IDX_MASK = 32'((64'd1 << INDEX_BITS) - 64'd1);

   logic [31:0] key;
   logic [31:0] key0;
   logic        in_order;
   logic        in_range;
   logic        skip;
   logic [31:0] target;
   logic [31:0] line_next;
   logic [33:0] end_sum;
   logic [33:0] end_bound;
   logic        end_over;
   logic [33:0] end_len;
   logic [33:0] start_len;
   logic [31:0] edge_word;
   result_type  first_r;
   result_type  last_r;

   always_comb begin
      key       = cfg.transpose_mode ? column_number : row_number;
      key0      = key - 32'd1;
      in_order  = key > prev_index;
      in_range  = (row_number != 32'd0) && (row_number <= cfg.row_count) &&
                  (column_number != 32'd0) && (column_number <= cfg.column_count);
      skip      = key0 > prev_index;
      target    = (cfg.transpose_mode ? row_number - 32'd1
                   : column_number - 32'd1 + cfg.row_count) & IDX_MASK;
      line_next = line_counter + 32'd1;
      edge_word = 32'(edges_seen);
      end_sum   = {2'b00, cfg.row_count} + {2'b00, cfg.column_count};
      end_bound = cfg.transpose_mode ? {2'b00, cfg.column_count} : end_sum - 34'd1;
      end_over  = (!cfg.transpose_mode && end_sum == 34'd0) ||
                  (end_bound > {2'b00, prev_index});
      end_len   = end_over ? end_bound - {2'b00, prev_index} + 34'd1 : 34'd1;
      start_len = (cfg.transpose_mode && cfg.row_count > 32'd1)
                  ? {2'b00, cfg.row_count} : 34'd1;

      first_r          = '0;
      last_r           = '0;
      result_count     = 2'd0;
      prev_index_in    = prev_index;
      edges_seen_in    = edges_seen;
      line_counter_in  = line_counter;
      limit_reached_in = limit_reached;

      case (opcode)
         OP_START: begin
            result_count       = 2'd1;
            last_r.result_kind = KIND_RUN;
            last_r.run_length  = start_len;
            prev_index_in      = 32'd0;
            edges_seen_in      = '0;
            line_counter_in    = 32'd1;
            limit_reached_in   = 1'b0;
         end
         OP_ENTRY: begin
            if (!limit_reached) begin
               if (!in_order) begin
                  result_count       = 2'd1;
                  last_r.result_kind = KIND_ERROR;
                  last_r.error_code  = ERR_ORDER;
               end else if (!in_range) begin
                  result_count       = 2'd1;
                  last_r.result_kind = KIND_ERROR;
                  last_r.error_code  = ERR_RANGE;
               end else begin
                  result_count        = skip ? 2'd2 : 2'd1;
                  first_r.result_kind = KIND_RUN;
                  first_r.offset_value = edge_word;
                  first_r.run_length  = {2'b00, key0 - prev_index};
                  last_r.result_kind  = KIND_EDGE;
                  last_r.edge_target  = target;
                  last_r.weight_out   = entry_weight;
                  prev_index_in       = key0;
                  edges_seen_in       = edges_seen + 1'b1;
                  line_counter_in     = line_next;
                  limit_reached_in    = (cfg.entry_limit != 32'd0) &&
                                        (line_next >= cfg.entry_limit);
               end
            end
         end
         OP_END: begin
            result_count         = 2'd2;
            first_r.result_kind  = KIND_RUN;
            first_r.offset_value = edge_word;
            first_r.run_length   = end_len;
            last_r.result_kind   = KIND_DONE;
            last_r.offset_value  = edge_word;
            last_r.error_code    = (edge_word != cfg.expected_nonzeros)
                                   ? ERR_MISMATCH : ERR_NONE;
         end
         default: begin
            result_count = 2'd0;
         end
      endcase

      is_last            = (result_count != 2'd2) || beat;
      result             = (!beat && result_count == 2'd2) ? first_r : last_r;
      result.last_of_run = is_last;
   end

endmodule

`default_nettype wire

// ===== sv/sctw_out.sv =====
// ----------------------------------------------------------------------------
// sctw_out
// Result register between the step logic and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sctw_out
   import sctw_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  wire result_type result,
   input  wire logic rsp_ready,
   output logic      out_free,
   output logic      rsp_valid,
   output result_type rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire
